@@ hdl/pcrd_pkg.sv @@
// shared constants for the clock rate decoder: rates, status and source codes,
// the fixed-rate divide table and the odd-divisor reciprocals
// no dependencies
package pcrd_pkg;

	localparam logic [31:0] XTAL_HZ      = 32'd26000000;
	localparam logic [31:0] FIXED_512_HZ = 32'd512000000;
	localparam logic [31:0] FIXED_768_HZ = 32'd768000000;

	localparam int FRAC_SHIFT = 23;
	localparam int RECIP_SHIFT = 34;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MODE    = 2'd1;
	localparam logic [1:0] ST_POSTDIV = 2'd2;

	// source codes
	localparam logic [1:0] SRC_XTAL = 2'd0;
	localparam logic [1:0] SRC_512  = 2'd1;
	localparam logic [1:0] SRC_768  = 2'd2;
	localparam logic [1:0] SRC_PLL  = 2'd3;

	// fixed source rate divided by divisor, row = source, column = divisor - 1
	// the pll row is unused and reads as zero
	localparam logic [31:0] FIXED_RATE [4][8] = '{
		'{XTAL_HZ / 1, XTAL_HZ / 2, XTAL_HZ / 3, XTAL_HZ / 4,
		  XTAL_HZ / 5, XTAL_HZ / 6, XTAL_HZ / 7, XTAL_HZ / 8},
		'{FIXED_512_HZ / 1, FIXED_512_HZ / 2, FIXED_512_HZ / 3, FIXED_512_HZ / 4,
		  FIXED_512_HZ / 5, FIXED_512_HZ / 6, FIXED_512_HZ / 7, FIXED_512_HZ / 8},
		'{FIXED_768_HZ / 1, FIXED_768_HZ / 2, FIXED_768_HZ / 3, FIXED_768_HZ / 4,
		  FIXED_768_HZ / 5, FIXED_768_HZ / 6, FIXED_768_HZ / 7, FIXED_768_HZ / 8},
		'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}
	};

	// floor(2^34 / odd) for the odd divisors
	localparam logic [32:0] RECIP_3 = 33'((64'd1 << RECIP_SHIFT) / 3);
	localparam logic [32:0] RECIP_5 = 33'((64'd1 << RECIP_SHIFT) / 5);
	localparam logic [32:0] RECIP_7 = 33'((64'd1 << RECIP_SHIFT) / 7);

	function automatic logic [32:0] recip(input logic [2:0] odd);
		logic [32:0] r;
		unique case (odd)
			3'd3: r = RECIP_3;
			3'd5: r = RECIP_5;
			3'd7: r = RECIP_7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/pcrd_divider.sv @@
// three-stage pipelined divider of a 32-bit value by a divisor of 1..8
// uses pcrd_pkg for the reciprocal constants
module pcrd_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [31:0] dividend,
	input  logic [2:0]  divm1,
	output logic        out_vld,
	output logic [31:0] quotient
);

	logic [1:0]  shift;
	logic [2:0]  odd;

	logic        vld_s3, vld_s4, vld_s5;
	logic [31:0] y_s3, y_s4;
	logic [2:0]  odd_s3, odd_s4;
	logic [32:0] recip_s3;
	logic [31:0] q0_s4;
	logic [31:0] q_s5;

	logic [64:0] prod;
	logic [34:0] q0_times_odd;
	logic [34:0] rem;

	// divisor = 2^shift * odd
	always_comb begin
		unique case (divm1)
			3'd0: begin shift = 2'd0; odd = 3'd1; end
			3'd1: begin shift = 2'd1; odd = 3'd1; end
			3'd2: begin shift = 2'd0; odd = 3'd3; end
			3'd3: begin shift = 2'd2; odd = 3'd1; end
			3'd4: begin shift = 2'd0; odd = 3'd5; end
			3'd5: begin shift = 2'd1; odd = 3'd3; end
			3'd6: begin shift = 2'd0; odd = 3'd7; end
			3'd7: begin shift = 2'd3; odd = 3'd1; end
			default: begin shift = 2'd0; odd = 3'd1; end
		endcase
	end

	assign prod = 65'(y_s3) * 65'(recip_s3);

	// estimate is exact or one short, fix with one compare
	assign q0_times_odd = 35'(q0_s4) * 35'(odd_s4);
	assign rem = 35'(y_s4) - q0_times_odd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= in_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		y_s3 <= dividend >> shift;
		odd_s3 <= odd;
		recip_s3 <= pcrd_pkg::recip(odd);

		y_s4 <= y_s3;
		odd_s4 <= odd_s3;
		if (odd_s3 == 3'd1) begin
			q0_s4 <= y_s3;
		end else begin
			q0_s4 <= 32'(prod[64:pcrd_pkg::RECIP_SHIFT]);
		end

		if (rem >= 35'(odd_s4)) begin
			q_s5 <= q0_s4 + 32'd1;
		end else begin
			q_s5 <= q0_s4;
		end
	end

	assign out_vld = vld_s5;
	assign quotient = q_s5;

	a_vld_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> $past(in_vld, 3))
		else $error("divider result without an operand three cycles earlier");

	a_rem_small: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> rem < 35'(2 * odd_s4))
		else $error("reciprocal estimate more than one below the quotient");

	a_bypass_exact: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && odd_s4 == 3'd1 |-> q0_s4 == y_s4)
		else $error("power-of-two divisor not taken as a plain shift");

endmodule

@@ hdl/pll_core_clock_rate_decoder_top.sv @@
// top level of the clock rate decoder: decode, pll rate, core divide
// depends on pcrd_pkg and pcrd_divider
//
// takes one snapshot of the five raw clock-control words per item and returns the
// fractional pll rate and the core clock rate in Hz. an item is accepted on any
// edge where start is high; busy is always low, so a new item may be offered every
// cycle. each item gives exactly one result, shown for one cycle with done high,
// in order. the receiver cannot stall, so there is no backpressure anywhere. the
// stages are: field decode and both multiplies by 26 MHz, rounding add and status,
// then three stages of the core divider (power-of-two shift and reciprocal lookup,
// reciprocal multiply and truncate, one-step fix). pll faults give a zero rate and
// a status code; a mode fault wins over a set postdivider, and the pre-postdivider
// rate is still given when only the postdivider is set.
module pll_core_clock_rate_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] source_select_word,
	input  logic [31:0] divider_word,
	input  logic [31:0] pll_control0,
	input  logic [31:0] pll_control1,
	input  logic [31:0] pll_control2,
	output logic        done,
	output logic [31:0] pll_rate_hz,
	output logic [1:0]  pll_status,
	output logic [31:0] pll_prepostdiv_hz,
	output logic [31:0] core_rate_hz,
	output logic [1:0]  core_status,
	output logic [1:0]  core_source,
	output logic [3:0]  core_divisor
);

	// input decode
	logic [6:0]  nint;
	logic [22:0] kint;
	logic        accept;

	// stage 1: fields and products
	logic        vld_s1;
	logic [31:0] nint_prod_s1;
	logic [47:0] frac_prod_s1;
	logic        mode_ok_s1, postdiv_s1;
	logic [1:0]  source_s1;
	logic [2:0]  divm1_s1;
	logic [31:0] fixed_s1;

	// stage 2: rounded rate and status
	logic        vld_s2;
	logic [48:0] frac_sum;
	logic [31:0] pre_s2, pll_rate_s2, fixed_s2;
	logic [1:0]  pll_status_s2, source_s2;
	logic [2:0]  divm1_s2;

	// side band riding along the divider
	logic [31:0] pre_s3, pre_s4, pre_s5;
	logic [31:0] pll_rate_s3, pll_rate_s4, pll_rate_s5;
	logic [31:0] fixed_s3, fixed_s4, fixed_s5;
	logic [1:0]  pll_status_s3, pll_status_s4, pll_status_s5;
	logic [1:0]  source_s3, source_s4, source_s5;
	logic [2:0]  divm1_s3, divm1_s4, divm1_s5;

	logic        div_vld;
	logic [31:0] div_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	assign nint = pll_control1[29:23];
	assign kint = pll_control1[22:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1 registers: both multiplies by the crystal rate side by side
	always_ff @(posedge clk) begin
		nint_prod_s1 <= 32'(nint) * pcrd_pkg::XTAL_HZ;
		frac_prod_s1 <= 48'(kint) * 48'(pcrd_pkg::XTAL_HZ);
		mode_ok_s1 <= pll_control0[0] && pll_control0[2] && (nint != 7'd0);
		postdiv_s1 <= pll_control2[0];
		source_s1 <= source_select_word[1:0];
		divm1_s1 <= divider_word[6:4];
		fixed_s1 <= pcrd_pkg::FIXED_RATE[source_select_word[1:0]][divider_word[6:4]];
	end

	// fraction rounded to nearest Hz
	assign frac_sum = 49'(frac_prod_s1) + (49'd1 << (pcrd_pkg::FRAC_SHIFT - 1));

	always_ff @(posedge clk) begin
		source_s2 <= source_s1;
		divm1_s2 <= divm1_s1;
		fixed_s2 <= fixed_s1;
		if (!mode_ok_s1) begin
			pre_s2 <= '0;
			pll_rate_s2 <= '0;
			pll_status_s2 <= pcrd_pkg::ST_MODE;
		end else if (postdiv_s1) begin
			pre_s2 <= nint_prod_s1 + 32'(frac_sum[48:pcrd_pkg::FRAC_SHIFT]);
			pll_rate_s2 <= '0;
			pll_status_s2 <= pcrd_pkg::ST_POSTDIV;
		end else begin
			pre_s2 <= nint_prod_s1 + 32'(frac_sum[48:pcrd_pkg::FRAC_SHIFT]);
			pll_rate_s2 <= nint_prod_s1 + 32'(frac_sum[48:pcrd_pkg::FRAC_SHIFT]);
			pll_status_s2 <= pcrd_pkg::ST_OK;
		end
	end

	// pll rate over core divisor; a faulted pll feeds zero, so the quotient is zero
	pcrd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.dividend (pll_rate_s2),
		.divm1    (divm1_s2),
		.out_vld  (div_vld),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		pre_s3 <= pre_s2;
		pre_s4 <= pre_s3;
		pre_s5 <= pre_s4;
		pll_rate_s3 <= pll_rate_s2;
		pll_rate_s4 <= pll_rate_s3;
		pll_rate_s5 <= pll_rate_s4;
		fixed_s3 <= fixed_s2;
		fixed_s4 <= fixed_s3;
		fixed_s5 <= fixed_s4;
		pll_status_s3 <= pll_status_s2;
		pll_status_s4 <= pll_status_s3;
		pll_status_s5 <= pll_status_s4;
		source_s3 <= source_s2;
		source_s4 <= source_s3;
		source_s5 <= source_s4;
		divm1_s3 <= divm1_s2;
		divm1_s4 <= divm1_s3;
		divm1_s5 <= divm1_s4;
	end

	// result select: fixed sources come from the table, the pll from the divider
	assign done = div_vld;
	assign pll_rate_hz = pll_rate_s5;
	assign pll_status = pll_status_s5;
	assign pll_prepostdiv_hz = pre_s5;
	assign core_source = source_s5;
	assign core_divisor = 4'(divm1_s5) + 4'd1;
	assign core_rate_hz = (source_s5 == pcrd_pkg::SRC_PLL) ? div_q : fixed_s5;
	assign core_status = (source_s5 == pcrd_pkg::SRC_PLL) ? pll_status_s5 : pcrd_pkg::ST_OK;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result without an item accepted five cycles earlier");

	a_pll_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && pll_status != pcrd_pkg::ST_OK |-> pll_rate_hz == 32'd0)
		else $error("pll rate given while pll faulted");

	a_mode_fault_pre: assert property (@(posedge clk) disable iff (!arst_n)
		done && pll_status == pcrd_pkg::ST_MODE |-> pll_prepostdiv_hz == 32'd0)
		else $error("pre-postdivider rate given with unsupported mode");

	a_core_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && core_status != pcrd_pkg::ST_OK |->
			core_source == pcrd_pkg::SRC_PLL && core_rate_hz == 32'd0)
		else $error("core fault without the pll as source, or with a rate");

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for pll_core_clock_rate_decoder_top: a predictor of
// the pll and core clock rates checks every result, with directed and random snapshots
// depends on pcrd_pkg and the decoder rtl
`timescale 1ns / 100ps

module tb_top;

	// one decoded snapshot, as the block reports it
	typedef struct {
		logic [31:0] pll_rate;
		logic [1:0]  pll_stat;
		logic [31:0] pll_pre;
		logic [31:0] core_rate;
		logic [1:0]  core_stat;
		logic [1:0]  core_src;
		logic [3:0]  core_div;
	} clock_rates_t;

	// all inputs start at known values, reset held from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] source_select_word = '0;
	logic [31:0] divider_word = '0;
	logic [31:0] pll_control0 = '0;
	logic [31:0] pll_control1 = '0;
	logic [31:0] pll_control2 = '0;

	logic        busy;
	logic        done;
	logic [31:0] pll_rate_hz;
	logic [1:0]  pll_status;
	logic [31:0] pll_prepostdiv_hz;
	logic [31:0] core_rate_hz;
	logic [1:0]  core_status;
	logic [1:0]  core_source;
	logic [3:0]  core_divisor;

	// rates predicted for accepted snapshots, oldest first
	clock_rates_t pending_rates[$];
	clock_rates_t oldest_rates;
	int           mismatch_count = 0;
	// chance in a hundred that the sender sits idle before an item, drawn again while it idles
	int           sender_idle_pct = 0;

	pll_core_clock_rate_decoder_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.source_select_word(source_select_word),
		.divider_word      (divider_word),
		.pll_control0      (pll_control0),
		.pll_control1      (pll_control1),
		.pll_control2      (pll_control2),
		.done              (done),
		.pll_rate_hz       (pll_rate_hz),
		.pll_status        (pll_status),
		.pll_prepostdiv_hz (pll_prepostdiv_hz),
		.core_rate_hz      (core_rate_hz),
		.core_status       (core_status),
		.core_source       (core_source),
		.core_divisor      (core_divisor)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// predictor: decode the five raw words into the rates the block should give
	function automatic clock_rates_t decode_clock_rates(input logic [31:0] src_w,
		input logic [31:0] div_w, input logic [31:0] ctl0, input logic [31:0] ctl1,
		input logic [31:0] ctl2);
		clock_rates_t r;
		logic [6:0]   mult;
		logic [22:0]  frac;
		logic [63:0]  frac_hz;
		logic [63:0]  pre;
		logic         mode_ok;
		mult = ctl1[29:23];
		frac = ctl1[22:0];
		// divide select and sigma-delta enable both set, and a nonzero multiplier
		mode_ok = ctl0[0] && ctl0[2] && (mult != '0);
		pre = '0;
		if (mode_ok) begin
			// fraction of 26 MHz, rounded to nearest by adding half an lsb
			frac_hz = (64'(frac) * 64'(pcrd_pkg::XTAL_HZ)
				+ (64'd1 << (pcrd_pkg::FRAC_SHIFT - 1))) >> pcrd_pkg::FRAC_SHIFT;
			pre = 64'(mult) * 64'(pcrd_pkg::XTAL_HZ) + frac_hz;
		end
		// a mode fault wins over a set postdivider
		if (!mode_ok)
			r.pll_stat = pcrd_pkg::ST_MODE;
		else if (ctl2[0])
			r.pll_stat = pcrd_pkg::ST_POSTDIV;
		else
			r.pll_stat = pcrd_pkg::ST_OK;
		r.pll_pre = pre[31:0];
		r.pll_rate = (r.pll_stat == pcrd_pkg::ST_OK) ? pre[31:0] : '0;
		r.core_src = src_w[1:0];
		r.core_div = {1'b0, div_w[6:4]} + 4'd1;
		r.core_stat = pcrd_pkg::ST_OK;
		case (r.core_src)
			pcrd_pkg::SRC_XTAL: r.core_rate = pcrd_pkg::XTAL_HZ / 32'(r.core_div);
			pcrd_pkg::SRC_512:  r.core_rate = pcrd_pkg::FIXED_512_HZ / 32'(r.core_div);
			pcrd_pkg::SRC_768:  r.core_rate = pcrd_pkg::FIXED_768_HZ / 32'(r.core_div);
			default: begin
				// pll parent: its status carries through, rate only when clean
				r.core_stat = r.pll_stat;
				r.core_rate = (r.pll_stat == pcrd_pkg::ST_OK) ?
					r.pll_rate / 32'(r.core_div) : '0;
			end
		endcase
		return r;
	endfunction

	// offer one snapshot and hold it until the block takes it; start is left high
	// so that a back-to-back item does not toggle it within one time step
	task automatic send_snapshot(input logic [31:0] src_w, input logic [31:0] div_w,
		input logic [31:0] ctl0, input logic [31:0] ctl1, input logic [31:0] ctl2);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		source_select_word <= src_w;
		divider_word <= div_w;
		pll_control0 <= ctl0;
		pll_control1 <= ctl1;
		pll_control2 <= ctl2;
		// outputs read here still hold their values from before the edge
		do
			@(posedge clk);
		while (busy);
		pending_rates.push_back(decode_clock_rates(src_w, div_w, ctl0, ctl1, ctl2));
	endtask

	function automatic void check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatch_count++;
		end
	endfunction

	// result checker: each strobe is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rates.size() == 0) begin
				$error("result with no item outstanding: core_rate_hz %0d", core_rate_hz);
				mismatch_count++;
			end else begin
				oldest_rates = pending_rates.pop_front();
				check_field("pll_rate_hz", oldest_rates.pll_rate, pll_rate_hz);
				check_field("pll_status", 32'(oldest_rates.pll_stat), 32'(pll_status));
				check_field("pll_prepostdiv_hz", oldest_rates.pll_pre, pll_prepostdiv_hz);
				check_field("core_rate_hz", oldest_rates.core_rate, core_rate_hz);
				check_field("core_status", 32'(oldest_rates.core_stat), 32'(core_status));
				check_field("core_source", 32'(oldest_rates.core_src), 32'(core_source));
				check_field("core_divisor", 32'(oldest_rates.core_div), 32'(core_divisor));
			end
		end
	end

	// fixed parents at the smallest and largest divisor; pll words random,
	// since they must not affect a fixed-parent core rate
	task automatic test_fixed_sources();
		logic [1:0] src;
		for (int s = 0; s < 3; s++) begin
			src = 2'(s);
			send_snapshot({30'h3FFF_FFFF, src}, 32'hFFFF_FF8F, $urandom, $urandom, $urandom);
			send_snapshot({30'($urandom_range(32'h3FFF_FFFF)), src}, 32'h0000_0070, $urandom,
				$urandom, $urandom);
		end
	endtask

	// pll decode: clean, each fault on its own and together, rounding cases
	task automatic test_pll_decode();
		logic [31:0] pll_sel;
		logic [31:0] sel_512;
		pll_sel = {30'h0, pcrd_pkg::SRC_PLL};
		sel_512 = {30'h0, pcrd_pkg::SRC_512};
		// smallest clean rate, one times the crystal
		send_snapshot(pll_sel, 32'h0, 32'h5, {2'b00, 7'd1, 23'h0}, 32'h0);
		// divide select missing
		send_snapshot(pll_sel, 32'h10, 32'h4, {2'b00, 7'd30, 23'h1234}, 32'h0);
		// sigma-delta enable missing
		send_snapshot(pll_sel, 32'h20, 32'h1, {2'b00, 7'd30, 23'h1234}, 32'h0);
		// zero multiplier with both mode bits set
		send_snapshot(pll_sel, 32'h30, 32'h5, {2'b11, 7'd0, 23'h7F_FFFF}, 32'h0);
		// postdivider alone: rate zero, pre-postdivider rate still given
		send_snapshot(pll_sel, 32'h40, 32'h5, {2'b00, 7'd64, 23'h40_0000}, 32'h1);
		// both faults, mode fault wins
		send_snapshot(pll_sel, 32'h50, 32'h4, {2'b00, 7'd64, 23'h40_0000}, 32'h1);
		// largest rate, largest divisor
		send_snapshot(pll_sel, 32'h70, 32'h5, {2'b00, 7'd127, 23'h7F_FFFF}, 32'h0);
		// fraction exactly half an lsb, rounds up
		send_snapshot(pll_sel, 32'h60, 32'h5, {2'b00, 7'd40, 23'h00_8000}, 32'h0);
		// smallest nonzero fraction
		send_snapshot(pll_sel, 32'h20, 32'h5, {2'b00, 7'd20, 23'h00_0001}, 32'h0);
		// fixed parent while the pll is faulted: core status stays clean
		send_snapshot(sel_512, 32'h30, 32'h0, {2'b00, 7'd0, 23'h0}, 32'h1);
	endtask

	// whole-word extremes, including every don't-care bit set
	task automatic test_word_extremes();
		send_snapshot('0, '0, '0, '0, '0);
		send_snapshot('1, '1, '1, '1, '1);
		send_snapshot('1, '1, '1, '1, 32'hFFFF_FFFE);
	endtask

	// random snapshots, mostly decodable pll setups with random content so
	// the divider sees real pll rates; the rest is noise and broken setups
	task automatic test_random_snapshots(input int count, input int idle_pct);
		logic [31:0] ctl0;
		logic [31:0] ctl1;
		logic [31:0] ctl2;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			ctl0 = $urandom;
			ctl1 = $urandom;
			ctl2 = $urandom;
			if ($urandom_range(99) < 80)
				ctl0 = ctl0 | 32'h5;
			if ($urandom_range(99) < 5)
				ctl1[29:23] = '0;
			if ($urandom_range(99) < 75)
				ctl2[0] = 1'b0;
			send_snapshot($urandom, $urandom, ctl0, ctl1, ctl2);
		end
	endtask

	initial begin
		int drain_cycles;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fixed_sources();
		test_pll_decode();
		test_word_extremes();
		// idling phases: none, sender mostly idle, none again, sender idle often
		test_random_snapshots(100, 0);
		test_random_snapshots(100, 85);
		test_random_snapshots(100, 0);
		test_random_snapshots(100, 38);
		start <= 1'b0;

		// let the pipeline drain, bounded in case results go missing
		drain_cycles = 0;
		while (pending_rates.size() != 0 && drain_cycles < 1000) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (pending_rates.size() != 0) begin
			$error("%0d items never produced a result", pending_rates.size());
			mismatch_count++;
		end
		// keep watching to catch any stray strobe
		repeat (10) @(posedge clk);

		if (mismatch_count == 0)
			$display("pll_core_clock_rate_decoder_top verification clean");
		else
			$display("pll_core_clock_rate_decoder_top verification failed");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#200000;
		$display("pll_core_clock_rate_decoder_top verification failed");
		$finish;
	end

endmodule
